// File: hdl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// shared types and constants for the screen fade sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  // command codes carried in in_tuser
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FADE_OUT = 2'd1,
    OP_FADE_IN  = 2'd2,
    OP_RESET    = 2'd3
  } op_t;

  // fade phase codes
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OUT  = 2'd1,
    PH_IN   = 2'd2
  } phase_t;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SETUP = 2'd1,
    ST_DIV   = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

  localparam int          COUNT_W          = 17;
  localparam int          ALPHA_W          = 8;
  localparam int          FIELD_LEN_W      = 16;
  localparam logic [7:0]  MODE_BLACK       = 8'd0;
  localparam logic [7:0]  MODE_FIXED_DONE  = 8'd2;
  localparam logic [16:0] FIXED_DONE_COUNT = 17'h1f;
  localparam logic [7:0]  ALPHA_MAX        = 8'd255;

endpackage

`default_nettype wire

// File: hdl/screen_fade_sequencer.sv
// ----------------------------------------------------------------------------
// screen_fade_sequencer
// fade-out / fade-in sequencer for a full-screen overlay with alpha output
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one command item per handshake; in_tuser holds the opcode
//           (tick, start fade-out, start fade-in, reset), in_tdata holds the
//           mode and the duration used by the start commands
//   out_* : one result item per command: phase, counter, done flag,
//           visibility, overlay alpha and patch select
// timing:
//   an item runs from the accept edge, which updates the fade state, through
//   the setup state, a bit-serial restoring divider (one quotient bit per
//   cycle into an 8-bit shift register) and the emit state; the next item
//   is accepted in the idle state that follows the loading of the result,
//   so no new item is taken before the previous result has been loaded
// reset:
//   rst_n low clears phase, counter, held mode and duration and drops
//   out_tvalid and in_tready; in_tready rises in the first cycle after reset
// stall:
//   the result sits in an output register; a new command may be accepted
//   while out_tready is low, but its result waits in the emit state until
//   the previous one has been taken
// ----------------------------------------------------------------------------
`default_nettype none

module screen_fade_sequencer #(
  parameter int DURATION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  input  wire logic [23:0] in_tdata,   // [7:0] fade_mode, [23:8] fade_length
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] phase_now, [18:2] count_now, [19] is_done, [20] overlay_visible,
  // [28:21] overlay_alpha, [29] white_patch, [31:30] zero
  output logic [31:0]      out_tdata
);
  import sfs_pkg::*;

  // duration is kept in at most the width of the field
  localparam int LEN_W = (DURATION_BITS < FIELD_LEN_W) ? DURATION_BITS : FIELD_LEN_W;

  // fade state
  logic [COUNT_W-1:0] tick_r, tick_nxt;
  phase_t             phase_r, phase_nxt;
  logic [7:0]         mode_r, mode_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;

  // sequencer
  state_t     state_r, state_nxt;
  logic [2:0] bit_cnt_r;
  logic       load_out;
  logic       accept;

  // divider
  logic [LEN_W-1:0] d_r;
  logic [LEN_W-1:0] rem_r;
  logic [7:0]       quo_r;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   rem_diff;
  logic             rem_ge;

  // captured result fields and alpha flags
  phase_t             res_phase_r;
  logic [COUNT_W-1:0] res_count_r;
  logic               res_done_r;
  logic               res_vis_r;
  logic               res_white_r;
  logic               fin_r;     // fade-in alpha form
  logic               force_r;   // alpha pinned to max
  logic               sat_r;     // quotient at or above 256

  // setup-cycle terms
  logic [COUNT_W-1:0] num_c;
  logic [LEN_W-1:0]   d_c;
  logic               short_c;
  logic               fin_c;
  logic               done_c;
  logic               vis_c;

  // output register
  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic [ALPHA_W-1:0] alpha_c;

  op_t        op_c;
  logic [7:0] in_mode;
  logic [LEN_W-1:0] in_len;

  assign op_c    = op_t'(in_tuser);
  assign in_mode = in_tdata[7:0];
  assign in_len  = in_tdata[8 +: LEN_W];

  // ---------------- sequencer next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_DIV;
      ST_DIV:   if (bit_cnt_r == 3'd7) state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = rst_n;
      ST_SETUP: ;
      ST_DIV:   ;
      ST_EMIT:  load_out = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // ---------------- command decode ----------------
  always_comb begin
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    unique case (op_c)
      OP_RESET: begin
        tick_nxt  = '0;
        phase_nxt = PH_IDLE;
        mode_nxt  = '0;
        len_nxt   = '0;
      end
      OP_FADE_OUT: begin
        tick_nxt  = COUNT_W'(1);
        phase_nxt = PH_OUT;
        mode_nxt  = in_mode;
        len_nxt   = in_len;
      end
      OP_FADE_IN: begin
        tick_nxt  = '0;
        phase_nxt = PH_IN;
        mode_nxt  = in_mode;
        len_nxt   = in_len;
      end
      OP_TICK: begin
        unique case (phase_r)
          PH_OUT: begin
            // saturate at duration + 1
            if (tick_r > COUNT_W'(len_r)) tick_nxt = COUNT_W'(len_r) + COUNT_W'(1);
            else                          tick_nxt = tick_r + COUNT_W'(1);
          end
          PH_IN: begin
            // past the duration the fade-in ends
            if (tick_r >= COUNT_W'(len_r)) begin
              tick_nxt  = '0;
              phase_nxt = PH_IDLE;
            end else begin
              tick_nxt = tick_r + COUNT_W'(1);
            end
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------- setup terms ----------------
  always_comb begin
    short_c = (len_r <= LEN_W'(2));
    fin_c   = (phase_r == PH_IN);
    d_c     = len_r - LEN_W'(2);
    num_c   = fin_c ? (tick_r - COUNT_W'(2)) : tick_r;
    vis_c   = (tick_r != '0);
    if (phase_r == PH_OUT) begin
      if (mode_r == MODE_FIXED_DONE) done_c = (tick_r == FIXED_DONE_COUNT);
      else                           done_c = (tick_r == COUNT_W'(len_r));
    end else begin
      done_c = 1'b0;
    end
  end

  // ---------------- divider step ----------------
  always_comb begin
    rem_sh   = {rem_r, 1'b0};
    rem_diff = rem_sh - {1'b0, d_r};
    rem_ge   = (rem_sh >= {1'b0, d_r});
  end

  // ---------------- alpha select ----------------
  always_comb begin
    priority if (!res_vis_r) begin
      alpha_c = '0;
    end else if (force_r) begin
      alpha_c = ALPHA_MAX;
    end else if (sat_r) begin
      alpha_c = fin_r ? '0 : ALPHA_MAX;
    end else begin
      alpha_c = fin_r ? (ALPHA_MAX - quo_r) : quo_r;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      phase_r     <= PH_IDLE;
      mode_r      <= '0;
      len_r       <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        tick_r  <= tick_nxt;
        phase_r <= phase_nxt;
        mode_r  <= mode_nxt;
        len_r   <= len_nxt;
      end
      if (state_r == ST_DIV) bit_cnt_r <= bit_cnt_r + 3'd1;
      else                   bit_cnt_r <= '0;
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      res_phase_r <= phase_r;
      res_count_r <= tick_r;
      res_done_r  <= done_c;
      res_vis_r   <= vis_c;
      res_white_r <= vis_c && (mode_r != MODE_BLACK);
      fin_r       <= fin_c;
      force_r     <= short_c || (fin_c && (tick_r < COUNT_W'(2)));
      // 256*n/d reaches 256 exactly when n >= d
      sat_r       <= (num_c >= COUNT_W'(d_c));
      d_r         <= d_c;
      rem_r       <= num_c[LEN_W-1:0];
      quo_r       <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_ge ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      quo_r <= {quo_r[6:0], rem_ge};
    end
    if (load_out) begin
      out_data_r <= {2'b00, res_white_r, alpha_c, res_vis_r, res_done_r,
                     res_count_r, res_phase_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// port-level checks for the screen fade sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  import sfs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one command at a time: no accept right after an accept
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while busy");

  // done only while fading out with a visible overlay
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tdata[1:0] == PH_OUT && out_tdata[20])
    else $error("done outside fade-out");

  // hidden overlay carries no alpha, no patch and a zero counter
  a_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[20] |-> out_tdata[29:21] == 9'd0 && out_tdata[18:2] == 17'd0)
    else $error("hidden overlay with drawing fields");

endmodule

bind screen_fade_sequencer sfs_checker u_sfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
